### sv/utf8_character_assembler_macros.svh
// Assertion macros for the UTF-8 character assembler.
// No dependencies; included by the top level.
`ifndef UTF8_CHARACTER_ASSEMBLER_MACROS_SVH
`define UTF8_CHARACTER_ASSEMBLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define UCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/utf8ca_pkg.sv
// Types, constants and the byte class function of the UTF-8 character assembler.
// No dependencies.
`default_nettype none

package utf8ca_pkg;

   typedef logic [3:0] dfa_state_type;
   typedef logic [3:0] byte_class_type;

   localparam dfa_state_type ST_ACCEPT = 4'd0;
   localparam dfa_state_type ST_REJECT = 4'd1;

   localparam logic STATUS_VALID   = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam int unsigned BUF_DEPTH = 4;

   typedef struct packed {
      logic        status;
      logic [31:0] char_data;
      logic [2:0]  char_length;
   } result_type;

   // next state, [state][byte class]; rows 9..15 unreachable
   localparam dfa_state_type NEXT_STATE [16][16] = '{
      '{4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1},
      '{4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1}
   };

   function automatic byte_class_type byte_class(input logic [7:0] b);
      byte_class_type c;
      if (b inside {[8'h00:8'h7F]})      c = 4'd0;
      else if (b inside {[8'h80:8'h8F]}) c = 4'd1;
      else if (b inside {[8'h90:8'h9F]}) c = 4'd9;
      else if (b inside {[8'hA0:8'hBF]}) c = 4'd7;
      else if (b inside {[8'hC0:8'hC1]}) c = 4'd8;
      else if (b inside {[8'hC2:8'hDF]}) c = 4'd2;
      else if (b == 8'hE0)               c = 4'd10;
      else if (b == 8'hED)               c = 4'd4;
      else if (b inside {[8'hE1:8'hEF]}) c = 4'd3;
      else if (b == 8'hF0)               c = 4'd11;
      else if (b inside {[8'hF1:8'hF3]}) c = 4'd6;
      else if (b == 8'hF4)               c = 4'd5;
      else                               c = 4'd8;
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/utf8_character_assembler.sv
// UTF-8 character assembler: one byte in per cycle unless req_stall is high, one character or error out.
// Uses utf8ca_pkg and utf8_character_assembler_macros.svh.
//
// Takes one byte per clock with no bubbles while the skid stage is empty. Each
// byte costs a single table lookup on the DFA state and byte class. A result is
// registered when the character's final byte is accepted. It lands in the
// output register if that register is empty or being taken in that cycle;
// otherwise it waits in a one-entry skid stage until the output register frees.
// req_stall rises only when the output register and the skid stage both hold
// results the receiver has not taken, and it drops in the cycle after the
// receiver takes an item.
`default_nettype none
`include "utf8_character_assembler_macros.svh"

module utf8_character_assembler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic [31:0]      rsp_char_data,
   output logic [2:0]       rsp_char_length
);
   import utf8ca_pkg::*;

   dfa_state_type state_ff;
   logic [7:0]    buf_ff [BUF_DEPTH];
   logic [2:0]    count_ff;

   logic          rsp_valid_ff;
   result_type    rsp_ff;
   logic          skid_valid_ff;
   result_type    skid_ff;

   logic          req_fire;
   logic          rsp_take;
   logic [1:0]    slot;
   logic [2:0]    count_in;
   logic [7:0]    buf_in [BUF_DEPTH];
   dfa_state_type next_state;
   logic          emit;
   result_type    res_in;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // buffer full guard: saturate on the last slot
   assign slot     = count_ff[2] ? 2'd3 : count_ff[1:0];
   assign count_in = {1'b0, slot} + 3'd1;

   always_comb begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
         buf_in[i] = (slot == 2'(i)) ? req_byte_value : buf_ff[i];
      end
   end

   assign next_state = NEXT_STATE[state_ff][byte_class(req_byte_value)];
   assign emit       = (next_state == ST_ACCEPT) || (next_state == ST_REJECT);

   assign res_in.status      = (next_state == ST_REJECT) ? STATUS_INVALID : STATUS_VALID;
   assign res_in.char_data   = {buf_in[3], buf_in[2], buf_in[1], buf_in[0]};
   assign res_in.char_length = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         count_ff <= 3'd0;
         for (int i = 0; i < BUF_DEPTH; i++) buf_ff[i] <= 8'h00;
      end else if (req_fire) begin
         if (emit) begin
            state_ff <= ST_ACCEPT;
            count_ff <= 3'd0;
            for (int i = 0; i < BUF_DEPTH; i++) buf_ff[i] <= 8'h00;
         end else begin
            state_ff <= next_state;
            count_ff <= count_in;
            for (int i = 0; i < BUF_DEPTH; i++) buf_ff[i] <= buf_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_ff        <= skid_ff;
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_fire && emit;
            if (req_fire && emit) rsp_ff <= res_in;
         end
      end else if (req_fire && emit) begin
         skid_ff       <= res_in;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_char_data   = rsp_ff.char_data;
   assign rsp_char_length = rsp_ff.char_length;

   `UCA_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid holds item while output empty")
   `UCA_ASSERT_SAME(a_accept_empty, clock, reset, state_ff == ST_ACCEPT, count_ff == 3'd0, "bytes pending in accept state")
   `UCA_ASSERT_SAME(a_never_reject, clock, reset, 1'b1, state_ff != ST_REJECT, "reject state stored")
   `UCA_ASSERT_NEXT(a_emit_visible, clock, reset, req_fire && emit, rsp_valid_ff, "result lost after final byte")

endmodule

`default_nettype wire
